@@ design/tmc_pkg.sv @@
// Shared types, codes and sizes for the touch median/calibration block.
// No dependencies; imported by every module of the block.
package tmc_pkg;

  localparam int MAX_SAMPLES = 9;
  localparam int SAMPLE_W    = 13;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SCALE_W     = 20;
  localparam int OFFSET_W    = 22;
  localparam int SIZE_W      = 13;
  localparam int COORD_W     = 12;
  localparam int CFG_W       = 22;
  localparam int PROD_W      = SCALE_W + SAMPLE_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int FRAC_W      = 16;
  localparam int OFF_SHIFT   = 8;
  localparam int SIZE_MAX    = 4096;
  localparam logic [SAMPLE_W-1:0] PRESENT_LIMIT = 13'd4095;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_POLL  = 2'd1,
    OP_X     = 2'd2,
    OP_Y     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_X_SCALE   = 3'd1,
    REG_X_OFFSET  = 3'd2,
    REG_Y_SCALE   = 3'd3,
    REG_Y_OFFSET  = 3'd4,
    REG_SWAP      = 3'd5,
    REG_WIDTH     = 3'd6,
    REG_HEIGHT    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MEDIAN = 4'b0010,
    ST_MAP    = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0]  x_scale;
    logic signed [OFFSET_W-1:0] x_offset;
    logic signed [SCALE_W-1:0]  y_scale;
    logic signed [OFFSET_W-1:0] y_offset;
    logic                       swap;
    logic [SIZE_W-1:0]          width;
    logic [SIZE_W-1:0]          height;
  } map_cfg_t;

endpackage

@@ design/touch_median_calibrate_core.sv @@
// Touch median filter and calibration: registers, sequencer, output register.
// After the closing beat of a group the rank search runs, then, for a pressed coordinate,
// the map unit, before out_valid rises from the output register.
// Throughput: one beat per cycle inside a group; the rank search, the shared
// multiplier and a stalled output hold in_ready low until the result is registered.
// Reset (rst, synchronous): registers to defaults, counts and flags to zero.
module touch_median_calibrate_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [tmc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [tmc_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic                         present,
  output logic                         pressed,
  output logic [tmc_pkg::SAMPLE_W-1:0] median,
  output logic [tmc_pkg::COORD_W-1:0]  screen_x,
  output logic [tmc_pkg::COORD_W-1:0]  screen_y
);
  import tmc_pkg::*;

  state_t              state;
  logic [SAMPLE_W-1:0] threshold;
  map_cfg_t            cfg;
  logic                present_flag;
  logic                pressed_flag;
  logic [SAMPLE_W-1:0] x_hold;
  logic [1:0]          op_hold;
  logic                push;
  logic                med_done;
  logic [SAMPLE_W-1:0] med;
  logic                map_start;
  logic                map_done;
  logic [COORD_W-1:0]  map_sx;
  logic [COORD_W-1:0]  map_sy;
  logic                coord;

  assign in_ready  = state == ST_IDLE;
  assign push      = in_valid && in_ready;
  assign map_start = (state == ST_MEDIAN) && med_done && (op_hold == OP_Y) && pressed_flag;
  assign coord     = (op_hold == OP_Y) && pressed_flag;

  tmc_median u_median (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (sample),
    .last   (last),
    .done   (med_done),
    .median (med)
  );

  tmc_map u_map (
    .clk     (clk),
    .rst     (rst),
    .start   (map_start),
    .cfg     (cfg),
    .cur_med (med),
    .x_hold  (x_hold),
    .done    (map_done),
    .sx      (map_sx),
    .sy      (map_sy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= 13'd300;
      cfg.x_scale  <= '0;
      cfg.x_offset <= '0;
      cfg.y_scale  <= '0;
      cfg.y_offset <= '0;
      cfg.swap     <= 1'b1;
      cfg.width    <= 13'd320;
      cfg.height   <= 13'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold    <= cfg_data[SAMPLE_W-1:0];
        REG_X_SCALE:   cfg.x_scale  <= cfg_data[SCALE_W-1:0];
        REG_X_OFFSET:  cfg.x_offset <= cfg_data[OFFSET_W-1:0];
        REG_Y_SCALE:   cfg.y_scale  <= cfg_data[SCALE_W-1:0];
        REG_Y_OFFSET:  cfg.y_offset <= cfg_data[OFFSET_W-1:0];
        REG_SWAP:      cfg.swap     <= cfg_data[0];
        REG_WIDTH:     cfg.width    <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    cfg.height   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      present_flag <= 1'b0;
      pressed_flag <= 1'b0;
      x_hold       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_EMIT)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (push && last) begin
            op_hold <= op;
            state   <= ST_MEDIAN;
          end
        end
        ST_MEDIAN: begin
          if (med_done) begin
            case (op_hold)
              OP_PROBE: present_flag <= med < PRESENT_LIMIT;
              OP_POLL:  pressed_flag <= present_flag && (med > threshold);
              OP_X:     x_hold       <= med;
              default: ;
            endcase
            state <= map_start ? ST_MAP : ST_EMIT;
          end
        end
        ST_MAP: begin
          if (map_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            kind      <= op_hold;
            present   <= present_flag;
            pressed   <= pressed_flag;
            median    <= med;
            screen_x  <= coord ? map_sx : '0;
            screen_y  <= coord ? map_sy : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/tmc_median.sv @@
// Sample store and rank search: one candidate per cycle against all kept samples.
// Depends on tmc_pkg.
module tmc_median (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [tmc_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          last,
  output logic                          done,
  output logic [tmc_pkg::SAMPLE_W-1:0]  median
);
  import tmc_pkg::*;

  logic [SAMPLE_W-1:0] store [MAX_SAMPLES];
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    n;
  logic [IDX_W-1:0]    cand;
  logic                busy;
  logic                room;
  logic [SAMPLE_W-1:0] cv;
  logic [CNT_W-1:0]    lt;
  logic [CNT_W-1:0]    le;
  logic [CNT_W-1:0]    k;
  logic                found;

  assign room       = count < CNT_W'(MAX_SAMPLES);
  assign count_next = room ? count + CNT_W'(1) : count;
  assign cv         = store[cand];
  assign k          = n >> 1;

  always_comb begin
    lt = '0;
    le = '0;
    for (int j = 0; j < MAX_SAMPLES; j++) begin
      if (CNT_W'(j) < n) begin
        if (store[j] < cv) lt = lt + CNT_W'(1);
        if (store[j] <= cv) le = le + CNT_W'(1);
      end
    end
  end

  assign found = (lt <= k) && (k < le);

  always_ff @(posedge clk) begin
    if (push && room) begin
      store[count[IDX_W-1:0]] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (push) begin
        if (last) begin
          n     <= count_next;
          count <= '0;
          busy  <= 1'b1;
          cand  <= '0;
        end else begin
          count <= count_next;
        end
      end else if (busy) begin
        if (found) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          median <= cv;
        end else begin
          cand <= cand + IDX_W'(1);
        end
      end
    end
  end

endmodule

@@ design/tmc_map.sv @@
// Affine map unit: one shared multiplier, then offset add, floor and clamp, per axis.
// Depends on tmc_pkg.
module tmc_map (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  tmc_pkg::map_cfg_t            cfg,
  input  logic [tmc_pkg::SAMPLE_W-1:0] cur_med,
  input  logic [tmc_pkg::SAMPLE_W-1:0] x_hold,
  output logic                         done,
  output logic [tmc_pkg::COORD_W-1:0]  sx,
  output logic [tmc_pkg::COORD_W-1:0]  sy
);
  import tmc_pkg::*;

  logic [1:0]                 phase;
  logic                       busy;
  logic                       axis;
  logic [SAMPLE_W-1:0]        raw_sel;
  logic signed [SCALE_W-1:0]  scale_sel;
  logic signed [OFFSET_W-1:0] off_sel;
  logic [SIZE_W-1:0]          size_sel;
  logic signed [ACC_W-1:0]    product;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic [ACC_W-FRAC_W-1:0]    whole;
  logic [COORD_W-1:0]         lim_m1;
  logic [COORD_W-1:0]         res;

  assign axis      = phase[1];
  assign raw_sel   = (axis ^ cfg.swap) ? cur_med : x_hold;
  assign scale_sel = axis ? cfg.y_scale : cfg.x_scale;
  assign off_sel   = axis ? cfg.y_offset : cfg.x_offset;
  assign size_sel  = axis ? cfg.height : cfg.width;

  assign product = ACC_W'(scale_sel) * ACC_W'($signed({1'b0, raw_sel}));
  assign acc     = ACC_W'(prod) + (ACC_W'(off_sel) <<< OFF_SHIFT);
  assign whole   = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (size_sel == '0) begin
      lim_m1 = '0;
    end else if (size_sel > SIZE_W'(SIZE_MAX)) begin
      lim_m1 = COORD_W'(SIZE_MAX - 1);
    end else begin
      lim_m1 = COORD_W'(size_sel - SIZE_W'(1));
    end
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (whole > (ACC_W-FRAC_W)'(lim_m1)) begin
      res = lim_m1;
    end else begin
      res = whole[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (!phase[0]) begin
          prod <= product[PROD_W-1:0];
        end else if (axis) begin
          sy   <= res;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          sx <= res;
        end
      end
    end
  end

endmodule

@@ design/tmc_checker.sv @@
// Port-level checks for touch_median_calibrate_core, attached by bind.
// Depends on tmc_pkg for field widths.
module tmc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   kind,
  input logic [tmc_pkg::SAMPLE_W-1:0] median,
  input logic [tmc_pkg::COORD_W-1:0]  screen_x,
  input logic [tmc_pkg::COORD_W-1:0]  screen_y
);
  import tmc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median) && $stable(kind))
    else $error("result beat changed while stalled");

  a_mid_group: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last |=> in_ready)
    else $error("ready dropped inside a group");

  a_group_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("ready held after group end");

  a_coord_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != OP_Y) |-> (screen_x == '0) && (screen_y == '0))
    else $error("screen fields nonzero on non-coordinate beat");

endmodule

bind touch_median_calibrate_core tmc_checker u_tmc_checker (.*);

@@ tb/touch_median_checker.sv @@
// Checker for touch_median_calibrate_core: follows register writes and input beats,
// predicts each report and compares it with the report beats the block emits.
// Depends on tmc_pkg for sizes, op codes and register indexes.
module touch_median_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [tmc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [tmc_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   kind,
  input  logic                         present,
  input  logic                         pressed,
  input  logic [tmc_pkg::SAMPLE_W-1:0] median,
  input  logic [tmc_pkg::COORD_W-1:0]  screen_x,
  input  logic [tmc_pkg::COORD_W-1:0]  screen_y,
  output int                           fail_count,
  output int                           reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmc_pkg::*;

  typedef struct packed {
    op_t                 kind;
    logic                present;
    logic                pressed;
    logic [SAMPLE_W-1:0] median;
    logic [COORD_W-1:0]  sx;
    logic [COORD_W-1:0]  sy;
  } touch_report_t;

  logic [SAMPLE_W-1:0] kept [MAX_SAMPLES];
  int                  kept_count;
  logic                present_q;
  logic                pressed_q;
  logic [SAMPLE_W-1:0] x_hold;
  logic [SAMPLE_W-1:0] threshold;
  map_cfg_t            mapping;
  touch_report_t       reports_due [$];
  int                  fails = 0;

  assign fail_count = fails;

  function automatic logic [SAMPLE_W-1:0] middle_reading(int n);
    logic [SAMPLE_W-1:0] v [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] key;
    int j;
    v = kept;
    for (int i = 1; i < n; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return v[n/2];
  endfunction

  function automatic logic [COORD_W-1:0] to_screen(logic [SAMPLE_W-1:0] raw,
                                                   logic signed [SCALE_W-1:0] scale,
                                                   logic signed [OFFSET_W-1:0] offset,
                                                   logic [SIZE_W-1:0] size);
    longint acc;
    longint lim;
    acc = longint'(scale) * longint'(raw) + longint'(offset) * 256;
    lim = longint'(size);
    if (lim < 1) lim = 1;
    if (lim > SIZE_MAX) lim = SIZE_MAX;
    if (acc < 0) return '0;
    acc = acc >>> FRAC_W;
    if (acc > lim - 1) acc = lim - 1;
    return acc[COORD_W-1:0];
  endfunction

  task automatic take_write(reg_idx_t idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_THRESHOLD: threshold        = d[SAMPLE_W-1:0];
      REG_X_SCALE:   mapping.x_scale  = d[SCALE_W-1:0];
      REG_X_OFFSET:  mapping.x_offset = d[OFFSET_W-1:0];
      REG_Y_SCALE:   mapping.y_scale  = d[SCALE_W-1:0];
      REG_Y_OFFSET:  mapping.y_offset = d[OFFSET_W-1:0];
      REG_SWAP:      mapping.swap     = d[0];
      REG_WIDTH:     mapping.width    = d[SIZE_W-1:0];
      REG_HEIGHT:    mapping.height   = d[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic absorb_reading(op_t o, logic [SAMPLE_W-1:0] s, logic l);
    touch_report_t r;
    logic [SAMPLE_W-1:0] raw_x;
    logic [SAMPLE_W-1:0] raw_y;
    if (kept_count < MAX_SAMPLES) begin
      kept[kept_count] = s;
      kept_count++;
    end
    if (!l) return;
    r = '0;
    r.kind = o;
    r.median = middle_reading(kept_count);
    kept_count = 0;
    case (o)
      OP_PROBE: present_q = r.median < PRESENT_LIMIT;
      OP_POLL:  pressed_q = present_q && (r.median > threshold);
      OP_X:     x_hold = r.median;
      default: begin
        if (pressed_q) begin
          raw_x = mapping.swap ? r.median : x_hold;
          raw_y = mapping.swap ? x_hold : r.median;
          r.sx = to_screen(raw_x, mapping.x_scale, mapping.x_offset, mapping.width);
          r.sy = to_screen(raw_y, mapping.y_scale, mapping.y_offset, mapping.height);
        end
      end
    endcase
    r.present = present_q;
    r.pressed = pressed_q;
    reports_due.push_back(r);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    touch_report_t want;
    if (rst) begin
      kept_count = 0;
      present_q = 1'b0;
      pressed_q = 1'b0;
      x_hold = '0;
      threshold = 13'd300;
      mapping = '0;
      mapping.swap = 1'b1;
      mapping.width = 13'd320;
      mapping.height = 13'd240;
      reports_due.delete();
    end else begin
      if (cfg_we) take_write(reg_idx_t'(cfg_index), cfg_data);
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("report beat with none due: kind %0d median %0d", kind, median);
          fails++;
        end else begin
          want = reports_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind));
          check_field("present", 16'(want.present), 16'(present));
          check_field("pressed", 16'(want.pressed), 16'(pressed));
          check_field("median", 16'(want.median), 16'(median));
          check_field("screen_x", 16'(want.sx), 16'(screen_x));
          check_field("screen_y", 16'(want.sy), 16'(screen_y));
        end
      end
      if (in_valid && in_ready) absorb_reading(op_t'(op), sample, last);
    end
    reports_pending <= reports_due.size();
  end

endmodule

@@ tb/tb_touch_median_calibrate_core.sv @@
// Top of the touch_median_calibrate_core testbench: clock, reset, register setup,
// sample beats with random idling on both channels, watchdog and verdict.
// Depends on tmc_pkg, the block and touch_median_checker.
module tb_touch_median_calibrate_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tmc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BEATS  = 93;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [1:0]          op        = OP_PROBE;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                last      = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic                present;
  logic                pressed;
  logic [SAMPLE_W-1:0] median;
  logic [COORD_W-1:0]  screen_x;
  logic [COORD_W-1:0]  screen_y;
  int                  fail_count;
  int                  reports_pending;

  int                  quiet      = 0;
  int                  beats_sent = 0;
  bit                  no_idle    = 1'b0;
  logic [SAMPLE_W-1:0] thr_now    = 13'd300;

  touch_median_calibrate_core u_dut (.*);
  touch_median_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int idle_gap();
    return no_idle ? 0 : int'($urandom_range(12, 0));
  endfunction

  function automatic int group_len();
    if ($urandom_range(99, 0) < 85) return $urandom_range(9, 1);
    return $urandom_range(14, 10);
  endfunction

  task automatic send_beat(op_t o, logic [SAMPLE_W-1:0] s, logic l);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    sample <= s;
    last <= l;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_group(op_t o, int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_beat(o, SAMPLE_W'($urandom_range(hi, lo)), i == n - 1);
  endtask

  task automatic send_mixed(int n);
    for (int i = 0; i < n; i++)
      send_beat(op_t'($urandom_range(3, 0)), SAMPLE_W'($urandom_range(8191, 0)), i == n - 1);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) thr_now = value[SAMPLE_W-1:0];
  endtask

  task automatic write_all(logic [CFG_W-1:0] t, int xs, int xo, int ys, int yo, bit sw,
                           int w, int h);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_X_SCALE, CFG_W'(xs));
    write_reg(REG_X_OFFSET, CFG_W'(xo));
    write_reg(REG_Y_SCALE, CFG_W'(ys));
    write_reg(REG_Y_OFFSET, CFG_W'(yo));
    write_reg(REG_SWAP, CFG_W'(sw));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  // wait until every report is back, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_scale();
    int v;
    if ($urandom_range(9, 0) < 2) return $urandom;
    v = $urandom_range(20000, 0);
    return ($urandom_range(6, 0) == 0) ? -v : v;
  endfunction

  function automatic int pick_offset();
    if ($urandom_range(9, 0) < 2) return $urandom;
    return int'($urandom_range(65535, 0)) - 16384;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) begin
      case ($urandom_range(4, 0))
        0: return 0;
        1: return 1;
        2: return 4096;
        3: return 4097;
        default: return 8191;
      endcase
    end
    if (r == 1) return $urandom;
    return $urandom_range(800, 16);
  endfunction

  task automatic program_random();
    logic [CFG_W-1:0] t;
    if ($urandom_range(4, 0) == 0) t = $urandom_range(1, 0) ? 22'd8191 : 22'd0;
    else if ($urandom_range(9, 0) == 0) t = CFG_W'($urandom);
    else t = CFG_W'($urandom_range(3000, 0));
    write_all(t, pick_scale(), pick_offset(), pick_scale(), pick_offset(),
              1'($urandom_range(1, 0)), pick_size(), pick_size());
  endtask

  // probe, poll (mostly), x, y: the sequence a touch controller runs per sample point
  task automatic one_touch();
    int lo;
    no_idle = ($urandom_range(4, 0) == 0);
    send_group(OP_PROBE, group_len(), 0, ($urandom_range(6, 0) == 0) ? 8191 : 4094);
    if ($urandom_range(9, 0) != 0) begin
      lo = ($urandom_range(3, 0) == 0 || thr_now == 13'd8191) ? 0 : int'(thr_now) + 1;
      send_group(OP_POLL, group_len(), lo, 8191);
    end
    send_group(OP_X, group_len(), 0, 8191);
    send_group(OP_Y, group_len(), 0, 8191);
  endtask

  task automatic random_phase(int beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      if ($urandom_range(4, 0) == 0) begin
        no_idle = 1'b0;
        if ($urandom_range(1, 0)) send_mixed(group_len());
        else send_group(op_t'($urandom_range(3, 0)), group_len(), 0, 8191);
      end else begin
        one_touch();
      end
    end
    settle();
  endtask

  initial begin : result_side
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: presence edge, threshold edge, y with zero mapping
    send_beat(OP_PROBE, 13'd4095, 1'b1);
    send_beat(OP_POLL, 13'd8191, 1'b1);
    send_beat(OP_PROBE, 13'd4094, 1'b1);
    send_beat(OP_POLL, 13'd300, 1'b1);
    send_beat(OP_POLL, 13'd301, 1'b1);
    send_beat(OP_Y, 13'd8191, 1'b1);
    send_beat(OP_PROBE, 13'd8191, 1'b0);
    send_beat(OP_PROBE, 13'd0, 1'b0);
    send_beat(OP_PROBE, 13'd8191, 1'b1);
    settle();

    write_all(22'd0, 16384, 10 * 256, -16384, 2000 * 256, 1'b0, 4096, 0);
    send_beat(OP_PROBE, 13'd100, 1'b1);
    send_beat(OP_POLL, 13'd1, 1'b1);
    // overfull x group, descending so the sort has work to do
    for (int i = 0; i < 10; i++) send_beat(OP_X, 13'(8100 - i * 900), i == 9);
    // mixed ops, closing op decides
    send_beat(OP_PROBE, 13'd7000, 1'b0);
    send_beat(OP_POLL, 13'd6000, 1'b0);
    send_beat(OP_Y, 13'd6500, 1'b1);
    settle();

    write_all(22'd0, 524287, 2097151, 524287, 2097151, 1'b1, 8191, 4096);
    random_phase(PHASE_BEATS);
    write_all(22'd8191, -524288, -2097152, -524288, -2097152, 1'b0, 0, 1);
    random_phase(PHASE_BEATS);
    write_all(22'd0, -524288, 2097151, 524287, -2097152, 1'b0, 1, 4096);
    random_phase(PHASE_BEATS);
    repeat (4) begin
      program_random();
      random_phase(PHASE_BEATS);
    end

    if (fail_count == 0 && reports_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
